@@ rtl/dfdc_pkg.sv @@
package dfdc_pkg;

  // gravity, 9.81 in Q16.16
  localparam logic [19:0] GRAV_Q16 = 20'd642908;
  localparam logic [47:0] DRAG_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [30:0] FLOOR_RESET = 31'd66;

  // root/quotient units: one result bit per stage
  localparam int unsigned SQ_STAGES = 32;
  localparam int unsigned CB_STAGES = 22;
  localparam int unsigned D1_STAGES = 51;
  localparam int unsigned D2_STAGES = 48;

  typedef enum logic {
    REG_VEL_FLOOR   = 1'b0,
    REG_DEPTH_FLOOR = 1'b1
  } reg_idx_t;

  // square root, cube root and rho*g/xi in flight
  typedef struct packed {
    logic        voe;
    logic        xi_zero;
    logic [30:0] rho;
    logic [61:0] pm;
    logic [47:0] k;
    logic [63:0] sq_x;
    logic [33:0] sq_r;
    logic [31:0] sq_q;
    logic [63:0] cb_x;
    logic [21:0] cb_y;
    logic [43:0] cb_y2;
    logic [30:0] lm_d;
    logic [31:0] lm_r;
    logic [50:0] lm_nq;
  } d1_t;

  // Voellmy p*mu/uu and Manning P/c quotients in flight
  typedef struct packed {
    logic        voe;
    logic        v_sat;
    logic [47:0] t2;
    logic [32:0] uu;
    logic [32:0] t1_r;
    logic [47:0] t1_nq;
    logic        m_sat;
    logic [21:0] c;
    logic [21:0] m_r;
    logic [47:0] m_nq;
  } d2_t;

endpackage

@@ rtl/debris_friction_drag_coef_unit.sv @@
// channel   direction  handshake              payload
// cell in   input      in_valid / in_stall    vel_x..manning_coef
// drag out  output     out_valid / out_stall  drag_coef, voellmy_used, saturated
// config    input      cfg_wr_en              cfg_index, cfg_data
//
// One cell per cycle while out_stall does not hold the chain.
// Latency is set by the square-root/cube-root/rho*g/xi stage chain (51 stages)
// and the two quotient units (48 stages), one result bit per stage each.
// Reset clears all valid bits; both floors return to 66.
// out_stall freezes the whole chain; in_stall is high only while a result waits.
module debris_friction_drag_coef_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  dfdc_pkg::reg_idx_t    cfg_index,
  input  logic [30:0]           cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    vel_x,
  input  logic signed [31:0]    vel_y,
  input  logic signed [31:0]    vel_z,
  input  logic [30:0]           flow_depth,
  input  logic [30:0]           density,
  input  logic [30:0]           basal_pressure,
  input  logic [30:0]           concentration,
  input  logic [30:0]           conc_limit,
  input  logic [30:0]           coulomb_coef,
  input  logic [30:0]           turbulence_coef,
  input  logic [30:0]           manning_coef,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [47:0]           drag_coef,
  output logic                  voellmy_used,
  output logic                  saturated
);
  import dfdc_pkg::*;

  logic [30:0] velocity_floor;
  logic [30:0] depth_floor;
  logic        adv;

  logic                 s1_v, s2_v;
  logic [D1_STAGES:0]   v1;
  logic [3:0]           e_v;
  logic [D2_STAGES:0]   v2;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      velocity_floor <= FLOOR_RESET;
      depth_floor    <= FLOOR_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_VEL_FLOOR:   velocity_floor <= cfg_data;
        REG_DEPTH_FLOOR: depth_floor    <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      v1        <= '0;
      e_v       <= '0;
      v2        <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_v      <= in_valid;
      s2_v      <= s1_v;
      v1        <= {v1[D1_STAGES-1:0], s2_v};
      e_v       <= {e_v[2:0], v1[D1_STAGES]};
      v2        <= {v2[D2_STAGES-1:0], e_v[3]};
      out_valid <= v2[D2_STAGES];
    end
  end

  // S1: magnitudes and operands
  logic [31:0] s1_ax, s1_ay, s1_az;
  logic [30:0] s1_h, s1_rho, s1_p, s1_mu, s1_xi, s1_n;
  logic        s1_voe;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ax  <= vel_x[31] ? (~$unsigned(vel_x) + 32'd1) : $unsigned(vel_x);
      s1_ay  <= vel_y[31] ? (~$unsigned(vel_y) + 32'd1) : $unsigned(vel_y);
      s1_az  <= vel_z[31] ? (~$unsigned(vel_z) + 32'd1) : $unsigned(vel_z);
      s1_h   <= flow_depth;
      s1_rho <= density;
      s1_p   <= basal_pressure;
      s1_mu  <= coulomb_coef;
      s1_xi  <= turbulence_coef;
      s1_n   <= manning_coef;
      s1_voe <= concentration >= conc_limit;
    end
  end

  // S2: products
  logic [63:0] s2_sx, s2_sy, s2_sz;
  logic [61:0] s2_pm, s2_nn;
  logic [50:0] s2_rhog;
  logic [31:0] s2_hh;
  logic [30:0] s2_rho, s2_xi;
  logic        s2_voe;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_sx   <= s1_ax * s1_ax;
      s2_sy   <= s1_ay * s1_ay;
      s2_sz   <= s1_az * s1_az;
      s2_pm   <= s1_p * s1_mu;
      s2_nn   <= s1_n * s1_n;
      s2_rhog <= s1_rho * GRAV_Q16;
      s2_hh   <= {1'b0, s1_h} + {1'b0, depth_floor};
      s2_rho  <= s1_rho;
      s2_xi   <= s1_xi;
      s2_voe  <= s1_voe;
    end
  end

  // S3: speed radicand, Manning gain k, unit seeds
  d1_t         d1 [D1_STAGES+1];
  logic [65:0] s3_mg;

  assign s3_mg = s2_nn[61:16] * GRAV_Q16;

  always_ff @(posedge clk) begin
    if (adv) begin
      d1[0].voe     <= s2_voe;
      d1[0].xi_zero <= s2_xi == 31'd0;
      d1[0].rho     <= s2_rho;
      d1[0].pm      <= s2_pm;
      d1[0].k       <= s3_mg[63:16];
      d1[0].sq_x    <= s2_sx + s2_sy + s2_sz;
      d1[0].sq_r    <= '0;
      d1[0].sq_q    <= '0;
      d1[0].cb_x    <= {s2_hh, 32'd0};
      d1[0].cb_y    <= '0;
      d1[0].cb_y2   <= '0;
      d1[0].lm_d    <= s2_xi;
      d1[0].lm_r    <= '0;
      d1[0].lm_nq   <= s2_rhog;
    end
  end

  for (genvar i = 0; i < D1_STAGES; i++) begin : g_d1
    localparam int SH = (i < CB_STAGES) ? (63 - 3 * i) : 0;
    d1_t         nx;
    logic [35:0] sq_rr, sq_tr;
    logic        sq_ge;
    logic [47:0] cb_b;
    logic [63:0] cb_bs;
    logic        cb_ge;
    logic [45:0] cb_y2n;
    logic [32:0] lm_r2;
    logic        lm_ge;

    always_comb begin
      nx     = d1[i];
      sq_rr  = {d1[i].sq_r, d1[i].sq_x[63:62]};
      sq_tr  = {2'b00, d1[i].sq_q, 2'b01};
      sq_ge  = sq_rr >= sq_tr;
      // b = 3*(2y)*(2y+1)+1 = 12y^2 + 6y + 1
      cb_b   = ({4'd0, d1[i].cb_y2} << 3) + ({4'd0, d1[i].cb_y2} << 2)
             + ({26'd0, d1[i].cb_y} << 2) + ({26'd0, d1[i].cb_y} << 1) + 48'd1;
      cb_bs  = {16'd0, cb_b} << SH;
      cb_ge  = (d1[i].cb_x >> SH) >= {16'd0, cb_b};
      cb_y2n = {d1[i].cb_y2, 2'b00}
             + (cb_ge ? ({22'd0, d1[i].cb_y, 2'b00} + 46'd1) : 46'd0);
      lm_r2  = {d1[i].lm_r, d1[i].lm_nq[50]};
      lm_ge  = lm_r2 >= {2'b00, d1[i].lm_d};
      if (i < SQ_STAGES) begin
        nx.sq_r = 34'(sq_ge ? (sq_rr - sq_tr) : sq_rr);
        nx.sq_q = {d1[i].sq_q[30:0], sq_ge};
        nx.sq_x = {d1[i].sq_x[61:0], 2'b00};
      end
      if (i < CB_STAGES) begin
        nx.cb_x  = cb_ge ? (d1[i].cb_x - cb_bs) : d1[i].cb_x;
        nx.cb_y  = {d1[i].cb_y[20:0], cb_ge};
        nx.cb_y2 = cb_y2n[43:0];
      end
      nx.lm_r  = 32'(lm_ge ? (lm_r2 - {2'b00, d1[i].lm_d}) : lm_r2);
      nx.lm_nq = {d1[i].lm_nq[49:0], lm_ge};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d1[i+1] <= nx;
      end
    end
  end

  d1_t d1o;
  assign d1o = d1[D1_STAGES];

  // E1: uu, rho*uu, lam*u halves
  logic [32:0] e1_uu;
  logic [63:0] e1_rr, e1_lu_lo;
  logic [50:0] e1_lu_hi;
  logic [61:0] e1_pm;
  logic [47:0] e1_k;
  logic [21:0] e1_c;
  logic        e1_voe, e1_xz;
  logic [32:0] uu_w;

  assign uu_w = {1'b0, d1o.sq_q} + {2'b00, velocity_floor};

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_uu    <= uu_w;
      e1_rr    <= d1o.rho * uu_w;
      e1_lu_lo <= d1o.lm_nq[31:0] * d1o.sq_q;
      e1_lu_hi <= d1o.lm_nq[50:32] * d1o.sq_q;
      e1_pm    <= d1o.pm;
      e1_k     <= d1o.k;
      e1_c     <= d1o.cb_y;
      e1_voe   <= d1o.voe;
      e1_xz    <= d1o.xi_zero;
    end
  end

  // E2: t2, k*R partials, t1 quotient seed
  logic [82:0] lamu;
  logic [47:0] e2_t2, e2_t1_nq;
  logic        e2_lovf, e2_t1_sat, e2_voe, e2_xz;
  logic [63:0] e2_pll, e2_plh;
  logic [47:0] e2_phl, e2_phh;
  logic [32:0] e2_t1_r, e2_uu;
  logic [21:0] e2_c;

  assign lamu = {e1_lu_hi, 32'd0} + {19'd0, e1_lu_lo};

  always_ff @(posedge clk) begin
    if (adv) begin
      e2_t2     <= lamu[63:16];
      e2_lovf   <= |lamu[82:64];
      e2_pll    <= e1_k[31:0] * e1_rr[31:0];
      e2_plh    <= e1_k[31:0] * e1_rr[63:32];
      e2_phl    <= e1_k[47:32] * e1_rr[31:0];
      e2_phh    <= e1_k[47:32] * e1_rr[63:32];
      // quotient reaches 2^48 exactly when pm>>48 >= uu (also uu == 0)
      e2_t1_sat <= {19'd0, e1_pm[61:48]} >= e1_uu;
      e2_t1_r   <= {19'd0, e1_pm[61:48]};
      e2_t1_nq  <= e1_pm[47:0];
      e2_uu     <= e1_uu;
      e2_c      <= e1_c;
      e2_voe    <= e1_voe;
      e2_xz     <= e1_xz;
    end
  end

  // E3, E4: sum k*R
  logic [95:0]  e3_a;
  logic [79:0]  e3_b;
  logic [111:0] e4_p;
  logic         e3_vsat, e4_vsat, e3_voe, e4_voe;
  logic [47:0]  e3_t2, e4_t2, e3_t1_nq, e4_t1_nq;
  logic [32:0]  e3_t1_r, e4_t1_r, e3_uu, e4_uu;
  logic [21:0]  e3_c, e4_c;

  always_ff @(posedge clk) begin
    if (adv) begin
      e3_a     <= {32'd0, e2_pll} + {e2_plh, 32'd0};
      e3_b     <= {e2_phh, 32'd0} + {32'd0, e2_phl};
      e3_vsat  <= e2_xz | e2_lovf | e2_t1_sat;
      e3_voe   <= e2_voe;
      e3_t2    <= e2_t2;
      e3_t1_nq <= e2_t1_nq;
      e3_t1_r  <= e2_t1_r;
      e3_uu    <= e2_uu;
      e3_c     <= e2_c;

      e4_p     <= {16'd0, e3_a} + {e3_b, 32'd0};
      e4_vsat  <= e3_vsat;
      e4_voe   <= e3_voe;
      e4_t2    <= e3_t2;
      e4_t1_nq <= e3_t1_nq;
      e4_t1_r  <= e3_t1_r;
      e4_uu    <= e3_uu;
      e4_c     <= e3_c;
    end
  end

  // E5: Manning quotient seed; P/c reaches 2^64 when P>>64 >= c (also c == 0)
  d2_t d2 [D2_STAGES+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      d2[0].voe   <= e4_voe;
      d2[0].v_sat <= e4_vsat;
      d2[0].t2    <= e4_t2;
      d2[0].uu    <= e4_uu;
      d2[0].t1_r  <= e4_t1_r;
      d2[0].t1_nq <= e4_t1_nq;
      d2[0].m_sat <= e4_p[111:64] >= {26'd0, e4_c};
      d2[0].c     <= e4_c;
      d2[0].m_r   <= e4_p[85:64];
      d2[0].m_nq  <= e4_p[63:16];
    end
  end

  for (genvar j = 0; j < D2_STAGES; j++) begin : g_d2
    d2_t         nx;
    logic [33:0] t_r2;
    logic        t_ge;
    logic [22:0] m_r2;
    logic        m_ge;

    always_comb begin
      nx       = d2[j];
      t_r2     = {d2[j].t1_r, d2[j].t1_nq[47]};
      t_ge     = t_r2 >= {1'b0, d2[j].uu};
      m_r2     = {d2[j].m_r, d2[j].m_nq[47]};
      m_ge     = m_r2 >= {1'b0, d2[j].c};
      nx.t1_r  = 33'(t_ge ? (t_r2 - {1'b0, d2[j].uu}) : t_r2);
      nx.t1_nq = {d2[j].t1_nq[46:0], t_ge};
      nx.m_r   = 22'(m_ge ? (m_r2 - {1'b0, d2[j].c}) : m_r2);
      nx.m_nq  = {d2[j].m_nq[46:0], m_ge};
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        d2[j+1] <= nx;
      end
    end
  end

  // F: combine and clip
  d2_t         d2o;
  logic [48:0] vsum;
  logic        f_sat;

  assign d2o   = d2[D2_STAGES];
  assign vsum  = {1'b0, d2o.t1_nq} + {1'b0, d2o.t2};
  assign f_sat = d2o.voe ? (d2o.v_sat | vsum[48]) : d2o.m_sat;

  always_ff @(posedge clk) begin
    if (adv) begin
      voellmy_used <= d2o.voe;
      saturated    <= f_sat;
      drag_coef    <= f_sat ? DRAG_MAX : (d2o.voe ? vsum[47:0] : d2o.m_nq);
    end
  end

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> drag_coef == DRAG_MAX)
    else $error("saturated result not clipped");

  a_manning_div: assert property (@(posedge clk) disable iff (rst)
    v2[0] && !d2[0].voe && !d2[0].m_sat |-> d2[0].c != 22'd0)
    else $error("Manning quotient with zero cube root");

  a_voellmy_div: assert property (@(posedge clk) disable iff (rst)
    v2[0] && d2[0].voe && !d2[0].v_sat |-> d2[0].uu != 33'd0)
    else $error("Voellmy quotient with zero speed");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !adv |=> out_valid && $stable(drag_coef))
    else $error("held result lost");

endmodule

@@ verif/debris_friction_drag_coef_unit_tb.sv @@
module debris_friction_drag_coef_unit_tb;
  import dfdc_pkg::*;

  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [30:0] h;
    logic [30:0] rho;
    logic [30:0] p;
    logic [30:0] cv;
    logic [30:0] cvlim;
    logic [30:0] mu;
    logic [30:0] xi;
    logic [30:0] n;
  } cell_t;

  typedef struct packed {
    logic [47:0] drag;
    logic        voe;
    logic        sat;
  } drag_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  reg_idx_t cfg_index = REG_VEL_FLOOR;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  cell_t cur = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [47:0] drag_coef;
  logic voellmy_used;
  logic saturated;

  cell_t pending_cells[$];
  drag_t expected_drag[$];
  logic [30:0] u0_floor = FLOOR_RESET;
  logic [30:0] h0_floor = FLOOR_RESET;
  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int stim_done = 0;

  debris_friction_drag_coef_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .vel_x(cur.vx), .vel_y(cur.vy), .vel_z(cur.vz),
    .flow_depth(cur.h), .density(cur.rho), .basal_pressure(cur.p),
    .concentration(cur.cv), .conc_limit(cur.cvlim),
    .coulomb_coef(cur.mu), .turbulence_coef(cur.xi), .manning_coef(cur.n),
    .out_valid(out_valid), .out_stall(out_stall),
    .drag_coef(drag_coef), .voellmy_used(voellmy_used), .saturated(saturated)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] int_sqrt(input logic [65:0] x);
    logic [65:0] r;
    logic [65:0] b;
    r = 0;
    b = 66'd1 << 64;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] int_cbrt(input logic [63:0] x);
    logic [127:0] y;
    logic [127:0] b;
    logic [127:0] xx;
    y = 0;
    xx = x;
    for (int s = 63; s >= 0; s -= 3) begin
      y = y << 1;
      b = 3 * y * (y + 1) + 1;
      if ((xx >> s) >= b) begin
        xx = xx - (b << s);
        y = y + 1;
      end
    end
    return y[31:0];
  endfunction

  function automatic drag_t predict_drag(input cell_t c);
    drag_t r;
    logic [31:0] ax, ay, az, u;
    logic [65:0] s;
    logic [32:0] uu;
    logic [191:0] t1, lam, t2, num, den, q, hh;
    logic [31:0] cb;
    logic [63:0] kw;
    ax = c.vx[31] ? -c.vx : c.vx;
    ay = c.vy[31] ? -c.vy : c.vy;
    az = c.vz[31] ? -c.vz : c.vz;
    s = 66'(ax) * ax + 66'(ay) * ay + 66'(az) * az;
    u = int_sqrt(s);
    uu = 33'(u) + u0_floor;
    r = '0;
    r.voe = c.cv >= c.cvlim;
    if (r.voe) begin
      if (uu == 0 || c.xi == 0) begin
        r.sat = 1'b1;
      end else begin
        t1 = (192'(c.p) * c.mu) / uu;
        lam = (192'(c.rho) * GRAV_Q16) / c.xi;
        t2 = (lam * u) >> 16;
        if (t1 + t2 > 192'(DRAG_MAX)) r.sat = 1'b1;
        else r.drag = 48'(t1 + t2);
      end
    end else begin
      hh = 192'(c.h) + h0_floor;
      cb = int_cbrt(64'(hh << 32));
      if (cb == 0) begin
        r.sat = 1'b1;
      end else begin
        // the gain product wraps at 64 bits before the shift
        kw = 64'(((192'(c.n) * c.n) >> 16) * GRAV_Q16);
        num = 192'(kw >> 16) * c.rho * uu;
        den = 192'(cb);
        q = num / den;
        if (q >= (192'd1 << 64)) r.sat = 1'b1;
        else r.drag = 48'(q >> 16);
      end
    end
    if (r.sat) r.drag = DRAG_MAX;
    return r;
  endfunction

  function automatic logic [31:0] pick_val();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 32'h4_0000);
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic cell_t rand_cell();
    cell_t c;
    c.vx = pick_val();
    c.vy = pick_val();
    c.vz = pick_val();
    c.h = 31'(pick_val());
    c.rho = 31'(pick_val());
    c.p = 31'(pick_val());
    c.cv = 31'(pick_val());
    c.cvlim = 31'(pick_val());
    c.mu = 31'(pick_val());
    c.xi = 31'(pick_val());
    c.n = 31'(pick_val());
    return c;
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        expected_drag.push_back(predict_drag(cur));
      end
      if (!in_valid || !in_stall) begin
        if (pending_cells.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur <= pending_cells.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    drag_t got, want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = '{drag_coef, voellmy_used, saturated};
        if (expected_drag.size() == 0) begin
          $display("%0t: unexpected result drag %h", $time, drag_coef);
          errors++;
        end else begin
          want = expected_drag.pop_front();
          if (got.drag !== want.drag)
            $display("%0t: drag_coef expected %h actual %h", $time, want.drag, got.drag);
          if (got.voe !== want.voe)
            $display("%0t: voellmy_used expected %b actual %b", $time, want.voe, got.voe);
          if (got.sat !== want.sat)
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
          if (got !== want) errors++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall);
    end
  end

  task automatic drain();
    while (pending_cells.size() > 0 || in_valid || expected_drag.size() > 0)
      @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_floor(input reg_idx_t idx, input logic [30:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_VEL_FLOOR) u0_floor = v;
    else h0_floor = v;
    @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall, input int count);
    cell_t c;
    send_idle = idle;
    recv_stall = stall;
    for (int i = 0; i < count; i++) begin
      c = rand_cell();
      // mostly realistic magnitudes so results are not all clipped
      if ($urandom_range(0, 3) != 0) begin
        c.vx = $signed(32'($urandom_range(0, 32'h40_0000))) - 32'sh20_0000;
        c.vy = $signed(32'($urandom_range(0, 32'h40_0000))) - 32'sh20_0000;
        c.vz = $signed(32'($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
        c.h = 31'($urandom_range(0, 31'h40_0000));
        c.rho = 31'($urandom_range(0, 31'h80_0000));
        c.p = 31'($urandom_range(0, 31'h400_0000));
        c.mu = 31'($urandom_range(0, 31'h1_0000));
        c.xi = 31'($urandom_range(0, 31'h100_0000));
        c.n = 31'($urandom_range(0, 31'h8000));
        c.cv = 31'($urandom_range(0, 31'h1_0000));
        c.cvlim = 31'($urandom_range(0, 31'h1_0000));
      end
      pending_cells.push_back(c);
    end
    drain();
  endtask

  initial begin
    cell_t c;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, both laws, zero divisors, overflow
    for (int i = 0; i < 20; i++) begin
      c = '0;
      c.cv = (i % 2) ? 31'h7FFF_FFFF : 31'h0;
      c.cvlim = (i % 2) ? 31'h0 : 31'h1;
      case (i / 2)
        0: ;
        1: c = {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, {8{31'h7FFF_FFFF}}};
        2: c = {32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, {8{31'h7FFF_FFFF}}};
        3: begin c.vx = 32'h0002_0000; c.rho = 31'h1_0000; c.p = 31'h1_0000;
                 c.mu = 31'h3333; c.xi = 31'h1F4_0000; c.n = 31'h0A3D;
                 c.h = 31'h1_0000; end
        4: begin c.vy = -32'sh0001_8000; c.rho = 31'h7FFF_FFFF; c.xi = 31'h1; c.n = 31'h7FFF_FFFF; end
        5: begin c.vz = 32'h1; c.p = 31'h7FFF_FFFF; c.mu = 31'h7FFF_FFFF; c.xi = 31'h0; end
        default: c = rand_cell();
      endcase
      c.cv = (i % 2) ? 31'h7FFF_FFFF : 31'h0;
      c.cvlim = (i % 2) ? 31'h0 : 31'h1;
      pending_cells.push_back(c);
    end
    drain();

    // zero floors make the zero-speed and zero-depth divisors reachable
    write_floor(REG_VEL_FLOOR, 31'd0);
    write_floor(REG_DEPTH_FLOOR, 31'd0);
    c = '0;
    pending_cells.push_back(c);
    c.xi = 31'h1_0000;
    c.cv = 31'h1;
    pending_cells.push_back(c);
    drain();

    run_phase(0, 0, 80);
    write_floor(REG_VEL_FLOOR, 31'h7FFF_FFFF);
    write_floor(REG_DEPTH_FLOOR, 31'h7FFF_FFFF);
    run_phase(84, 0, 80);
    write_floor(REG_VEL_FLOOR, 31'h1_0000);
    write_floor(REG_DEPTH_FLOOR, 31'h8000);
    run_phase(0, 84, 80);
    write_floor(REG_VEL_FLOOR, FLOOR_RESET);
    write_floor(REG_DEPTH_FLOOR, FLOOR_RESET);
    run_phase(34, 34, 80);
    write_floor(REG_VEL_FLOOR, 31'($urandom));
    write_floor(REG_DEPTH_FLOOR, 31'($urandom));
    run_phase($urandom_range(0, 50), $urandom_range(0, 50), 80);

    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ debris_friction_drag_coef_unit.f @@
rtl/dfdc_pkg.sv
rtl/debris_friction_drag_coef_unit.sv
verif/debris_friction_drag_coef_unit_tb.sv
